>>> design/mer_pkg.sv
package mer_pkg;

    // Geometry widths.
    localparam int AXIS_BITS = 10;
    localparam int PT_W      = AXIS_BITS + 1;
    localparam int SQ_W      = 2 * AXIS_BITS;
    // Small signed factors such as 4x+3 or 2y-3.
    localparam int FAC_W     = AXIS_BITS + 3;
    localparam int PROD_W    = SQ_W + 1 + FAC_W;
    // Decision value, four times the real midpoint decision.
    localparam int DEC_W     = 4 * AXIS_BITS + 8;

    // Operand pairs of the shared multiplier.
    typedef enum logic [3:0] {
        MUL_SQ_A,
        MUL_SQ_B,
        MUL_A2_B,
        MUL_B2_X2P2,
        MUL_A2_Y2M1,
        MUL_B2_X2P3,
        MUL_A2_Y2M2,
        MUL_B2_X4P3,
        MUL_A2_Y4M3,
        MUL_A2_Y2M3
    } mul_sel_t;

    // Updates of the decision accumulator.
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_INIT,
        ACC_SUB1,
        ACC_ADD4,
        ACC_SUB4
    } acc_op_t;

    typedef struct packed {
        logic           latch_start;
        logic           mul_en;
        mul_sel_t       mul_sel;
        logic           load_a2;
        logic           load_b2;
        logic           load_cmp;
        logic           save_pos;
        acc_op_t        acc_op;
        logic           x_inc;
        logic           y_dec;
        logic           out_load;
        logic [1:0]     out_idx;
    } cmd_t;

    typedef struct packed {
        logic lt;
        logic dec_pos;
        logic y_zero;
        logic out_free;
    } status_t;

endpackage

>>> design/mer_ifs.sv
interface mer_in_if;
    import mer_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [AXIS_BITS-1:0] axis_a;
    logic [AXIS_BITS-1:0] axis_b;

    modport source (output valid, output mode, output axis_a, output axis_b, input ready);
    modport sink   (input valid, input mode, input axis_a, input axis_b, output ready);
endinterface

interface mer_out_if;
    import mer_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic                   last_of_step;
    logic                   finished;

    modport source (output valid, output point_x, output point_y, output last_of_step,
                    output finished, input ready);
    modport sink   (input valid, input point_x, input point_y, input last_of_step,
                    input finished, output ready);
endinterface

>>> design/mer_datapath.sv
module mer_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mer_pkg::cmd_t                 cmd,
    input  logic [mer_pkg::AXIS_BITS-1:0] axis_a,
    input  logic [mer_pkg::AXIS_BITS-1:0] axis_b,
    output mer_pkg::status_t              status,
    mer_out_if.source                     point
);
    import mer_pkg::*;

    logic [AXIS_BITS-1:0] axis_a_reg;
    logic [AXIS_BITS-1:0] axis_b_reg;
    logic [AXIS_BITS-1:0] x_reg;
    logic [AXIS_BITS-1:0] y_reg;
    logic [SQ_W-1:0]      a2_reg;
    logic [SQ_W-1:0]      b2_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    cmp_reg;
    logic [DEC_W-1:0]     dec_reg;
    logic [DEC_W-1:0]     dec_next;
    logic                 dec_pos_reg;

    logic                 out_valid_reg;
    logic [PT_W-1:0]      out_x_reg;
    logic [PT_W-1:0]      out_y_reg;
    logic                 out_last_reg;
    logic                 out_fin_reg;

    logic [FAC_W-1:0]         xe;
    logic [FAC_W-1:0]         ye;
    logic [SQ_W-1:0]          op1;
    logic [FAC_W-1:0]         fac;
    logic signed [PROD_W-1:0] prod_next;
    logic [DEC_W-1:0]         prod_ext;
    logic [DEC_W-1:0]         prod4;
    logic                     dec_is_pos;
    logic [PT_W-1:0]          xp;
    logic [PT_W-1:0]          yp;
    logic [PT_W-1:0]          xn;
    logic [PT_W-1:0]          yn;

    // Multiplier operand selection; factors wrap modulo 2^FAC_W and read as signed.
    assign xe = FAC_W'(x_reg);
    assign ye = FAC_W'(y_reg);

    always_comb
    begin
        op1 = b2_reg;
        fac = '0;
        case (cmd.mul_sel)
            MUL_SQ_A:
            begin
                op1 = SQ_W'(axis_a_reg);
                fac = FAC_W'(axis_a_reg);
            end
            MUL_SQ_B:
            begin
                op1 = SQ_W'(axis_b_reg);
                fac = FAC_W'(axis_b_reg);
            end
            MUL_A2_B:
            begin
                op1 = a2_reg;
                fac = FAC_W'(axis_b_reg);
            end
            MUL_B2_X2P2:
            begin
                op1 = b2_reg;
                fac = (xe << 1) + FAC_W'(2);
            end
            MUL_A2_Y2M1:
            begin
                op1 = a2_reg;
                fac = (ye << 1) - FAC_W'(1);
            end
            MUL_B2_X2P3:
            begin
                op1 = b2_reg;
                fac = (xe << 1) + FAC_W'(3);
            end
            MUL_A2_Y2M2:
            begin
                op1 = a2_reg;
                fac = (ye << 1) - FAC_W'(2);
            end
            MUL_B2_X4P3:
            begin
                op1 = b2_reg;
                fac = (xe << 2) + FAC_W'(3);
            end
            MUL_A2_Y4M3:
            begin
                op1 = a2_reg;
                fac = (ye << 2) - FAC_W'(3);
            end
            MUL_A2_Y2M3:
            begin
                op1 = a2_reg;
                fac = (ye << 1) - FAC_W'(3);
            end
            default:
            begin
                op1 = b2_reg;
                fac = '0;
            end
        endcase
    end

    assign prod_next = $signed({1'b0, op1}) * $signed(fac);

    // Decision accumulator, modulo 2^DEC_W.
    assign prod_ext = {{(DEC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign prod4    = prod_ext << 2;

    always_comb
    begin
        case (cmd.acc_op)
            ACC_HOLD: dec_next = dec_reg;
            ACC_INIT: dec_next = DEC_W'({b2_reg, 2'b00}) + DEC_W'(a2_reg);
            ACC_SUB1: dec_next = dec_reg - prod_ext;
            ACC_ADD4: dec_next = dec_reg + prod4;
            ACC_SUB4: dec_next = dec_reg - prod4;
            default:  dec_next = dec_reg;
        endcase
    end

    assign dec_is_pos = !dec_reg[DEC_W-1] && (dec_reg != '0);

    // Arithmetic registers.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_start)
        begin
            axis_a_reg <= axis_a;
            axis_b_reg <= axis_b;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.load_a2)
        begin
            a2_reg <= prod_reg[SQ_W-1:0];
        end
        if (cmd.load_b2)
        begin
            b2_reg <= prod_reg[SQ_W-1:0];
        end
        if (cmd.load_cmp)
        begin
            cmp_reg <= prod_reg;
        end
        if (cmd.save_pos)
        begin
            dec_pos_reg <= dec_is_pos;
        end
        dec_reg <= dec_next;
        if (cmd.latch_start)
        begin
            x_reg <= '0;
            y_reg <= axis_b;
        end
        else
        begin
            if (cmd.x_inc)
            begin
                x_reg <= x_reg + AXIS_BITS'(1);
            end
            if (cmd.y_dec)
            begin
                y_reg <= y_reg - AXIS_BITS'(1);
            end
        end
    end

    // Mirrored copies of the current point.
    assign xp = {1'b0, x_reg};
    assign yp = {1'b0, y_reg};
    assign xn = PT_W'(0) - xp;
    assign yn = PT_W'(0) - yp;

    // Output register: holds one word until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (point.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (cmd.out_idx)
                2'd0:
                begin
                    out_x_reg <= xp;
                    out_y_reg <= yp;
                end
                2'd1:
                begin
                    out_x_reg <= xn;
                    out_y_reg <= yn;
                end
                2'd2:
                begin
                    out_x_reg <= xn;
                    out_y_reg <= yp;
                end
                default:
                begin
                    out_x_reg <= xp;
                    out_y_reg <= yn;
                end
            endcase
            out_last_reg <= (cmd.out_idx == 2'd3);
            out_fin_reg  <= (y_reg == '0);
        end
    end

    assign point.valid        = out_valid_reg;
    assign point.point_x      = $signed(out_x_reg);
    assign point.point_y      = $signed(out_y_reg);
    assign point.last_of_step = out_last_reg;
    assign point.finished     = out_fin_reg;

    // Status back to the controller.
    assign status.lt       = (y_reg != '0) && ($signed(cmp_reg) < $signed(prod_reg));
    assign status.dec_pos  = dec_pos_reg;
    assign status.y_zero   = (y_reg == '0);
    assign status.out_free = !out_valid_reg || point.ready;

    // A new word is never loaded over one that the sink has not taken.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || point.ready))
        else $error("output word overwritten before it was taken");

    // The scan never steps y below zero.
    a_y_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.y_dec && !cmd.latch_start) |-> (y_reg != '0))
        else $error("y decremented at zero");

endmodule

>>> design/mer_controller.sv
module mer_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_mode,
    output logic             in_ready,
    input  mer_pkg::status_t status,
    output mer_pkg::cmd_t    cmd
);
    import mer_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_S1,
        ST_S2,
        ST_S3,
        ST_S4,
        ST_S5,
        ST_R1_A,
        ST_R1_B,
        ST_R1_C,
        ST_R1_D,
        ST_R1_E,
        ST_SW_A,
        ST_SW_B,
        ST_R2_A,
        ST_R2_B,
        ST_R2_C,
        ST_DONE,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_R1,
        PH_R2
    } phase_t;

    state_t     state_reg;
    state_t     state_next;
    phase_t     phase_reg;
    phase_t     phase_next;
    logic [1:0] k_reg;
    logic [1:0] k_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Sequencing of one word: multiplies, accumulates, then four emits unless the ellipse is done.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!in_mode)
                    begin
                        cmd.latch_start = 1'b1;
                        state_next      = ST_S1;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_R1:   state_next = ST_R1_A;
                            PH_R2:   state_next = ST_R2_A;
                            default: state_next = ST_IDLE;
                        endcase
                    end
                end
            end
            ST_S1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SQ_A;
                state_next  = ST_S2;
            end
            ST_S2:
            begin
                cmd.load_a2 = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SQ_B;
                state_next  = ST_S3;
            end
            ST_S3:
            begin
                cmd.load_b2 = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_A2_B;
                state_next  = ST_S4;
            end
            ST_S4:
            begin
                cmd.acc_op = ACC_INIT;
                state_next = ST_S5;
            end
            ST_S5:
            begin
                cmd.acc_op = ACC_SUB4;
                phase_next = status.y_zero ? PH_IDLE : PH_R1;
                k_next     = 2'd0;
                state_next = ST_EMIT;
            end
            // Region one: test 2b^2(x+1) against a^2(2y-1).
            ST_R1_A:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_B2_X2P2;
                state_next  = ST_R1_B;
            end
            ST_R1_B:
            begin
                cmd.load_cmp = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_A2_Y2M1;
                state_next   = ST_R1_C;
            end
            ST_R1_C:
            begin
                cmd.mul_en = 1'b1;
                if (status.lt)
                begin
                    cmd.mul_sel  = MUL_B2_X2P3;
                    cmd.save_pos = 1'b1;
                    state_next   = ST_R1_D;
                end
                else
                begin
                    cmd.mul_sel = MUL_B2_X4P3;
                    state_next  = ST_SW_A;
                end
            end
            ST_R1_D:
            begin
                cmd.acc_op  = ACC_ADD4;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_A2_Y2M2;
                state_next  = ST_R1_E;
            end
            ST_R1_E:
            begin
                if (status.dec_pos)
                begin
                    cmd.acc_op = ACC_SUB4;
                    cmd.y_dec  = 1'b1;
                end
                cmd.x_inc  = 1'b1;
                state_next = ST_DONE;
            end
            // Switch to region two: subtract b^2(4x+3) and a^2(4y-3).
            ST_SW_A:
            begin
                cmd.acc_op  = ACC_SUB1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_A2_Y4M3;
                state_next  = ST_SW_B;
            end
            ST_SW_B:
            begin
                cmd.acc_op = ACC_SUB1;
                phase_next = PH_R2;
                state_next = ST_R2_A;
            end
            // Region two iteration.
            ST_R2_A:
            begin
                if (status.y_zero)
                begin
                    phase_next = PH_IDLE;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.mul_en   = 1'b1;
                    cmd.mul_sel  = MUL_B2_X2P2;
                    cmd.save_pos = 1'b1;
                    state_next   = ST_R2_B;
                end
            end
            ST_R2_B:
            begin
                if (!status.dec_pos)
                begin
                    cmd.acc_op = ACC_ADD4;
                    cmd.x_inc  = 1'b1;
                end
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_A2_Y2M3;
                state_next  = ST_R2_C;
            end
            ST_R2_C:
            begin
                cmd.acc_op = ACC_SUB4;
                cmd.y_dec  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.y_zero)
                begin
                    phase_next = PH_IDLE;
                end
                k_next     = 2'd0;
                state_next = ST_EMIT;
            end
            // Four mirrored points, one per free output slot.
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_idx  = k_reg;
                    k_next       = k_reg + 2'd1;
                    if (k_reg == 2'd3)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_IDLE;
            k_reg     <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            k_reg     <= k_next;
        end
    end

    // An ellipse left in progress always has points still to go.
    a_live_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && phase_reg != PH_IDLE) |-> !status.y_zero)
        else $error("ellipse in progress with y at zero");

    // A stalled output holds the emit sequence where it is.
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !status.out_free) |=>
        (state_reg == ST_EMIT && $stable(k_reg)))
        else $error("emit sequence advanced while output stalled");

endmodule

>>> design/midpoint_ellipse_rasterizer_core.sv
// Midpoint ellipse rasterizer. A start word (mode 0) loads the semi-axes and
// yields the four mirrored copies of (0,b); each step word (mode 1) runs one
// iteration of the midpoint scan and yields four mirrored points in the order
// (x,y), (-x,-y), (-x,y), (x,-y), with last_of_step on the fourth and finished
// on all four of the final step. A step after the ellipse is done is taken and
// yields nothing. Words are handled one at a time by a sequencer that drives a
// single shared multiplier and a decision accumulator; a stalled sink holds
// the output points. The output register lets the next word be taken while
// the last point waits.
module midpoint_ellipse_rasterizer_core (
    input  logic      clk,
    input  logic      rst_n,
    mer_in_if.sink    step,
    mer_out_if.source point
);
    import mer_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    in_ready;

    assign step.ready = in_ready;

    mer_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (step.valid),
        .in_mode  (step.mode),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mer_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .axis_a (step.axis_a),
        .axis_b (step.axis_b),
        .status (status),
        .point  (point)
    );

endmodule
